[rtl/core/slm_pkg.sv]
// Shared types and constants of the syscall latency monitor core.
// Used by slm_front, slm_back, the top level and the checker; no dependencies.
package slm_pkg;

  // table sizes
  localparam int PENDING_DEPTH = 1024;
  localparam int STATS_DEPTH   = 512;

  // index and count widths of the tables
  localparam int PIDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PCNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int SIDX_W = (STATS_DEPTH > 1) ? $clog2(STATS_DEPTH) : 1;
  localparam int SCNT_W = $clog2(STATS_DEPTH + 1);

  localparam logic [63:0] THRESHOLD_RESET = 64'd50000000;

  // command codes
  localparam logic CMD_ENTER = 1'b0;
  localparam logic CMD_EXIT  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ENTER_STORED  = 2'd0;
  localparam logic [1:0] ST_ENTER_DROPPED = 2'd1;
  localparam logic [1:0] ST_EXIT_MATCHED  = 2'd2;
  localparam logic [1:0] ST_EXIT_NOMATCH  = 2'd3;

  // one input word as held in the queue
  typedef struct packed {
    logic        is_exit;
    logic [63:0] thread_id;
    logic [63:0] timestamp_ns;
    logic [63:0] group_id;
    logic [31:0] call_number;
    logic        call_failed;
  } item_t;

  // one result word
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] process_id;
    logic [63:0] group_out;
    logic [31:0] call_out;
    logic [63:0] call_latency;
    logic        slow_event;
    logic        stats_kept;
    logic [63:0] call_count;
    logic [63:0] failure_count;
    logic [63:0] latency_total_ns;
  } result_t;

  // queue handshake between front and back
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // pending table entry
  typedef struct packed {
    logic        valid;
    logic [63:0] thread;
    logic [63:0] time_ns;
  } pend_entry_t;

  // statistics table entry
  typedef struct packed {
    logic [63:0] group;
    logic [31:0] call;
    logic [63:0] count;
    logic [63:0] fails;
    logic [63:0] total;
  } stat_entry_t;

endpackage

[rtl/core/slm_front.sv]
// Front end: accepts input words, classifies the command and queues them.
// Depends on slm_pkg.
module slm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  logic [63:0]          in_thread_id,
  input  logic [63:0]          in_timestamp_ns,
  input  logic [63:0]          in_group_id,
  input  logic [31:0]          in_call_number,
  input  logic                 in_call_failed,
  output slm_pkg::queue_head_t head,
  input  logic                 pop
);

  slm_pkg::item_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  logic           do_pop;
  slm_pkg::item_t new_item;

  // classify the incoming word
  always_comb begin
    new_item.is_exit      = (in_command == slm_pkg::CMD_EXIT);
    new_item.thread_id    = in_thread_id;
    new_item.timestamp_ns = in_timestamp_ns;
    new_item.group_id     = in_group_id;
    new_item.call_number  = in_call_number;
    new_item.call_failed  = in_call_failed;
  end

  assign busy   = (cnt_r == 2'd2);
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != 2'd0);

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

[rtl/core/slm_back.sv]
// Back end: scans the pending and statistics tables and builds each result.
// Depends on slm_pkg; fed by slm_front.
module slm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slm_pkg::queue_head_t head,
  output logic                 pop,
  input  logic [63:0]          threshold,
  output logic                 res_valid,
  output slm_pkg::result_t     res
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_PRD   = 11'b00000000010,
    S_PCHK  = 11'b00000000100,
    S_PHIT  = 11'b00000001000,
    S_PMISS = 11'b00000010000,
    S_SSTRT = 11'b00000100000,
    S_SRD   = 11'b00001000000,
    S_SCHK  = 11'b00010000000,
    S_SMISS = 11'b00100000000,
    S_SUPD  = 11'b01000000000,
    S_SPARE = 11'b10000000000
  } state_t;

  localparam logic [slm_pkg::PCNT_W-1:0] P_FULL = slm_pkg::PCNT_W'(slm_pkg::PENDING_DEPTH);
  localparam logic [slm_pkg::SCNT_W-1:0] S_FULL = slm_pkg::SCNT_W'(slm_pkg::STATS_DEPTH);

  state_t                     state_r, state_nxt;
  slm_pkg::item_t             cur_r, cur_nxt;
  logic [slm_pkg::PCNT_W-1:0] idx_r, idx_nxt;
  logic [slm_pkg::PCNT_W-1:0] hwm_r, hwm_nxt;
  logic                       free_found_r, free_found_nxt;
  logic [slm_pkg::PIDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [slm_pkg::PIDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [63:0]                hit_time_r, hit_time_nxt;
  logic [63:0]                lat_r, lat_nxt;
  logic                       slow_r, slow_nxt;
  logic [slm_pkg::SCNT_W-1:0] sidx_r, sidx_nxt;
  logic [slm_pkg::SCNT_W-1:0] fill_r, fill_nxt;
  logic                       res_valid_r, res_valid_nxt;
  slm_pkg::result_t           res_r, res_nxt;

  // pending table memory
  slm_pkg::pend_entry_t       pmem [slm_pkg::PENDING_DEPTH];
  slm_pkg::pend_entry_t       p_rd_r;
  logic                       p_re, p_we;
  logic [slm_pkg::PIDX_W-1:0] p_raddr, p_waddr;
  slm_pkg::pend_entry_t       p_wdata;

  // statistics table memory
  slm_pkg::stat_entry_t       smem [slm_pkg::STATS_DEPTH];
  slm_pkg::stat_entry_t       s_rd_r;
  logic                       s_re, s_we;
  logic [slm_pkg::SIDX_W-1:0] s_raddr, s_waddr;
  slm_pkg::stat_entry_t       s_wdata;

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    if (p_re) begin
      p_rd_r <= pmem[p_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rd_r <= smem[s_raddr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    idx_nxt        = idx_r;
    hwm_nxt        = hwm_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    hit_idx_nxt    = hit_idx_r;
    hit_time_nxt   = hit_time_r;
    lat_nxt        = lat_r;
    slow_nxt       = slow_r;
    sidx_nxt       = sidx_r;
    fill_nxt       = fill_r;
    res_valid_nxt  = 1'b0;
    res_nxt        = res_r;
    pop            = 1'b0;
    p_re           = 1'b0;
    p_we           = 1'b0;
    p_raddr        = idx_r[slm_pkg::PIDX_W-1:0];
    p_waddr        = hit_idx_r;
    p_wdata.valid  = 1'b1;
    p_wdata.thread = cur_r.thread_id;
    p_wdata.time_ns = cur_r.timestamp_ns;
    s_re           = 1'b0;
    s_we           = 1'b0;
    s_raddr        = sidx_r[slm_pkg::SIDX_W-1:0];
    s_waddr        = sidx_r[slm_pkg::SIDX_W-1:0];
    s_wdata.group  = cur_r.group_id;
    s_wdata.call   = cur_r.call_number;
    s_wdata.count  = s_rd_r.count + 64'd1;
    s_wdata.fails  = s_rd_r.fails + {63'd0, cur_r.call_failed};
    s_wdata.total  = s_rd_r.total + lat_r;

    // result defaults: process id, key, latency and slow flag from the working registers, status matched, rest zero
    res_nxt                  = '0;
    res_nxt.process_id       = cur_r.thread_id[63:32];
    res_nxt.group_out        = cur_r.group_id;
    res_nxt.call_out         = cur_r.call_number;
    res_nxt.call_latency     = lat_r;
    res_nxt.slow_event       = slow_r;
    res_nxt.status           = slm_pkg::ST_EXIT_MATCHED;

    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop            = 1'b1;
          cur_nxt        = head.item;
          idx_nxt        = '0;
          free_found_nxt = 1'b0;
          state_nxt      = (hwm_r == '0) ? S_PMISS : S_PRD;
        end
      end
      // pending scan: read one entry, check it next cycle
      S_PRD: begin
        p_re      = 1'b1;
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (p_rd_r.valid && (p_rd_r.thread == cur_r.thread_id)) begin
          hit_idx_nxt  = idx_r[slm_pkg::PIDX_W-1:0];
          hit_time_nxt = p_rd_r.time_ns;
          state_nxt    = S_PHIT;
        end else begin
          if (!p_rd_r.valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = idx_r[slm_pkg::PIDX_W-1:0];
          end
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ((idx_r + 1'b1) == hwm_r) ? S_PMISS : S_PRD;
        end
      end
      S_PHIT: begin
        p_we = 1'b1;
        if (cur_r.is_exit) begin
          p_wdata.valid = 1'b0;
          lat_nxt       = cur_r.timestamp_ns - hit_time_r;
          state_nxt     = S_SSTRT;
        end else begin
          res_nxt            = '0;
          res_nxt.process_id = cur_r.thread_id[63:32];
          res_nxt.status     = slm_pkg::ST_ENTER_STORED;
          res_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      S_PMISS: begin
        res_nxt            = '0;
        res_nxt.process_id = cur_r.thread_id[63:32];
        res_valid_nxt      = 1'b1;
        state_nxt          = S_IDLE;
        if (cur_r.is_exit) begin
          res_nxt.status = slm_pkg::ST_EXIT_NOMATCH;
        end else if (free_found_r) begin
          p_we           = 1'b1;
          p_waddr        = free_idx_r;
          res_nxt.status = slm_pkg::ST_ENTER_STORED;
        end else if (hwm_r != P_FULL) begin
          p_we           = 1'b1;
          p_waddr        = hwm_r[slm_pkg::PIDX_W-1:0];
          hwm_nxt        = hwm_r + 1'b1;
          res_nxt.status = slm_pkg::ST_ENTER_STORED;
        end else begin
          res_nxt.status = slm_pkg::ST_ENTER_DROPPED;
        end
      end
      // slow flag, then statistics scan over the filled prefix
      S_SSTRT: begin
        slow_nxt  = (lat_r > threshold);
        sidx_nxt  = '0;
        state_nxt = (fill_r == '0) ? S_SMISS : S_SRD;
      end
      S_SRD: begin
        s_re      = 1'b1;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if ((s_rd_r.group == cur_r.group_id) && (s_rd_r.call == cur_r.call_number)) begin
          state_nxt = S_SUPD;
        end else begin
          sidx_nxt  = sidx_r + 1'b1;
          state_nxt = ((sidx_r + 1'b1) == fill_r) ? S_SMISS : S_SRD;
        end
      end
      S_SUPD: begin
        s_we                     = 1'b1;
        res_nxt.stats_kept       = 1'b1;
        res_nxt.call_count       = s_wdata.count;
        res_nxt.failure_count    = s_wdata.fails;
        res_nxt.latency_total_ns = s_wdata.total;
        res_valid_nxt            = 1'b1;
        state_nxt                = S_IDLE;
      end
      S_SMISS: begin
        res_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (fill_r != S_FULL) begin
          s_we                     = 1'b1;
          s_waddr                  = fill_r[slm_pkg::SIDX_W-1:0];
          s_wdata.count            = 64'd1;
          s_wdata.fails            = {63'd0, cur_r.call_failed};
          s_wdata.total            = lat_r;
          fill_nxt                 = fill_r + 1'b1;
          res_nxt.stats_kept       = 1'b1;
          res_nxt.call_count       = 64'd1;
          res_nxt.failure_count    = {63'd0, cur_r.call_failed};
          res_nxt.latency_total_ns = lat_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hwm_r       <= '0;
      fill_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hwm_r       <= hwm_nxt;
      fill_r      <= fill_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    idx_r        <= idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_time_r   <= hit_time_nxt;
    lat_r        <= lat_nxt;
    slow_r       <= slow_nxt;
    sidx_r       <= sidx_nxt;
    if (res_valid_nxt) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

[rtl/core/syscall_latency_monitor_core.sv]
// Top level of the syscall latency monitor: front queue, back sequencer and
// the slow threshold register. Depends on slm_pkg, slm_front and slm_back.
//
// Usage:
//   Input channel: a word is taken at a clock edge with start high and busy
//   low. A two-word queue sits behind the port, so busy rises only when two
//   words wait behind the one at work.
//   Result channel: each accepted word gives exactly one result, shown for
//   one cycle with out_valid high. The receiver cannot stall the block.
//   Config: cfg_we writes cfg_wdata into the slow threshold at once; write
//   it only while the block is idle.
//   Scan: the pending table is scanned entry by entry, each read and then
//   checked, up to its high-water mark, and on a matched exit the
//   statistics table over its filled entries, with one memory read port
//   on each table. The back end takes a new word from the queue only once
//   it is through with the last one.
//   Reset: both tables read as empty, the threshold returns to 50000000,
//   and no clearing pass is needed.
module syscall_latency_monitor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [63:0] in_thread_id,
  input  logic [63:0] in_timestamp_ns,
  input  logic [63:0] in_group_id,
  input  logic [31:0] in_call_number,
  input  logic        in_call_failed,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_process_id,
  output logic [63:0] out_group_out,
  output logic [31:0] out_call_out,
  output logic [63:0] out_call_latency,
  output logic        out_slow_event,
  output logic        out_stats_kept,
  output logic [63:0] out_call_count,
  output logic [63:0] out_failure_count,
  output logic [63:0] out_latency_total_ns
);

  slm_pkg::queue_head_t head;
  logic                 pop;
  slm_pkg::result_t     res;
  logic [63:0]          thresh_r, thresh_nxt;

  // slow threshold register
  assign thresh_nxt = cfg_we ? cfg_wdata : thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= slm_pkg::THRESHOLD_RESET;
    end else begin
      thresh_r <= thresh_nxt;
    end
  end

  slm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_thread_id    (in_thread_id),
    .in_timestamp_ns (in_timestamp_ns),
    .in_group_id     (in_group_id),
    .in_call_number  (in_call_number),
    .in_call_failed  (in_call_failed),
    .head            (head),
    .pop             (pop)
  );

  slm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .threshold (thresh_r),
    .res_valid (out_valid),
    .res       (res)
  );

  // result fields to ports
  assign out_status           = res.status;
  assign out_process_id       = res.process_id;
  assign out_group_out        = res.group_out;
  assign out_call_out         = res.call_out;
  assign out_call_latency     = res.call_latency;
  assign out_slow_event       = res.slow_event;
  assign out_stats_kept       = res.stats_kept;
  assign out_call_count       = res.call_count;
  assign out_failure_count    = res.failure_count;
  assign out_latency_total_ns = res.latency_total_ns;

endmodule

[rtl/core/slm_checker.sv]
// Port-level checks of the syscall latency monitor core, bound to the top.
// Depends on slm_pkg and syscall_latency_monitor_core.
module slm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [63:0] out_call_latency,
  input logic        out_slow_event,
  input logic        out_stats_kept,
  input logic [63:0] out_call_count,
  input logic [63:0] out_failure_count
);

  // no result straight out of reset
  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

  // results other than a matched exit carry no latency or statistics
  a_unmatched_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != slm_pkg::ST_EXIT_MATCHED) |->
      (out_call_latency == 64'd0 && !out_slow_event && !out_stats_kept))
    else $error("unmatched result carries data");

  // a kept statistics entry has counted at least this call
  a_kept_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stats_kept) |-> (out_call_count != 64'd0))
    else $error("kept entry with bad count");

  // no statistics kept means zero counts
  a_not_kept_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stats_kept) |->
      (out_call_count == 64'd0 && out_failure_count == 64'd0))
    else $error("counts without a statistics entry");

endmodule

bind syscall_latency_monitor_core slm_checker u_slm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_call_latency  (out_call_latency),
  .out_slow_event    (out_slow_event),
  .out_stats_kept    (out_stats_kept),
  .out_call_count    (out_call_count),
  .out_failure_count (out_failure_count)
);

[dv/testbench.sv]
// Self-checking testbench of syscall_latency_monitor_core: directed and random
// words against a latency scoreboard. Depends on slm_pkg and syscall_latency_monitor_core.
module testbench;

  localparam int CYCLE_LIMIT = 8000000;

  // scoreboard: own copy of both tables, the threshold and the expected results
  class latency_scoreboard;
    logic [63:0]      threshold;
    bit               pend_v   [slm_pkg::PENDING_DEPTH];
    logic [63:0]      pend_tid [slm_pkg::PENDING_DEPTH];
    logic [63:0]      pend_ts  [slm_pkg::PENDING_DEPTH];
    bit               stat_v   [slm_pkg::STATS_DEPTH];
    logic [63:0]      stat_grp [slm_pkg::STATS_DEPTH];
    logic [31:0]      stat_call[slm_pkg::STATS_DEPTH];
    logic [63:0]      stat_cnt [slm_pkg::STATS_DEPTH];
    logic [63:0]      stat_fail[slm_pkg::STATS_DEPTH];
    logic [63:0]      stat_sum [slm_pkg::STATS_DEPTH];
    slm_pkg::result_t expected_q[$];
    int               errors;

    function new();
      threshold = slm_pkg::THRESHOLD_RESET;
      errors = 0;
      foreach (pend_v[i]) pend_v[i] = 1'b0;
      foreach (stat_v[i]) stat_v[i] = 1'b0;
    endfunction

    // predict the result of one accepted word
    function void note_word(logic cmd, logic [63:0] tid, logic [63:0] ts,
                            logic [63:0] grp, logic [31:0] cnum, logic failed);
      slm_pkg::result_t r;
      int p, s;
      logic [63:0] lat;
      r = '0;
      r.process_id = tid[63:32];
      p = -1;
      s = -1;
      foreach (pend_v[i]) if (p < 0 && pend_v[i] && pend_tid[i] == tid) p = i;
      if (cmd == slm_pkg::CMD_ENTER) begin
        foreach (pend_v[i]) if (p < 0 && !pend_v[i]) p = i;
        if (p < 0) begin
          r.status = slm_pkg::ST_ENTER_DROPPED;
        end else begin
          pend_v[p] = 1'b1;
          pend_tid[p] = tid;
          pend_ts[p] = ts;
          r.status = slm_pkg::ST_ENTER_STORED;
        end
      end else if (p < 0) begin
        r.status = slm_pkg::ST_EXIT_NOMATCH;
      end else begin
        lat = ts - pend_ts[p];
        pend_v[p] = 1'b0;
        r.status = slm_pkg::ST_EXIT_MATCHED;
        r.group_out = grp;
        r.call_out = cnum;
        r.call_latency = lat;
        r.slow_event = lat > threshold;
        foreach (stat_v[i])
          if (s < 0 && stat_v[i] && stat_grp[i] == grp && stat_call[i] == cnum) s = i;
        if (s < 0) begin
          foreach (stat_v[i]) if (s < 0 && !stat_v[i]) s = i;
          if (s >= 0) begin
            stat_v[s] = 1'b1;
            stat_grp[s] = grp;
            stat_call[s] = cnum;
            stat_cnt[s] = '0;
            stat_fail[s] = '0;
            stat_sum[s] = '0;
          end
        end
        if (s >= 0) begin
          stat_cnt[s] += 64'd1;
          stat_sum[s] += lat;
          if (failed) stat_fail[s] += 64'd1;
          r.stats_kept = 1'b1;
          r.call_count = stat_cnt[s];
          r.failure_count = stat_fail[s];
          r.latency_total_ns = stat_sum[s];
        end
      end
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    // compare one result word with the oldest expectation
    task check_word(slm_pkg::result_t got);
      slm_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result word", {62'd0, got.status}, 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          report("status", 64'(got.status), 64'(want.status));
        if (got.process_id !== want.process_id)
          report("process_id", 64'(got.process_id), 64'(want.process_id));
        if (got.group_out !== want.group_out)
          report("group_out", got.group_out, want.group_out);
        if (got.call_out !== want.call_out)
          report("call_out", 64'(got.call_out), 64'(want.call_out));
        if (got.call_latency !== want.call_latency)
          report("call_latency", got.call_latency, want.call_latency);
        if (got.slow_event !== want.slow_event)
          report("slow_event", 64'(got.slow_event), 64'(want.slow_event));
        if (got.stats_kept !== want.stats_kept)
          report("stats_kept", 64'(got.stats_kept), 64'(want.stats_kept));
        if (got.call_count !== want.call_count)
          report("call_count", got.call_count, want.call_count);
        if (got.failure_count !== want.failure_count)
          report("failure_count", got.failure_count, want.failure_count);
        if (got.latency_total_ns !== want.latency_total_ns)
          report("latency_total_ns", got.latency_total_ns, want.latency_total_ns);
      end
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_command;
  logic [63:0]      in_thread_id;
  logic [63:0]      in_timestamp_ns;
  logic [63:0]      in_group_id;
  logic [31:0]      in_call_number;
  logic             in_call_failed;
  logic             cfg_we;
  logic [63:0]      cfg_wdata;
  logic             out_valid;
  slm_pkg::result_t res;

  latency_scoreboard sb;
  int          accepted;
  int          cycles;
  bit          idle_on;
  logic [63:0] now_ts;
  logic [63:0] tid_pool[24];
  logic [63:0] grp_pool[6];
  logic [31:0] call_pool[4];

  syscall_latency_monitor_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_thread_id(in_thread_id),
    .in_timestamp_ns(in_timestamp_ns), .in_group_id(in_group_id),
    .in_call_number(in_call_number), .in_call_failed(in_call_failed),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_status(res.status), .out_process_id(res.process_id),
    .out_group_out(res.group_out), .out_call_out(res.call_out),
    .out_call_latency(res.call_latency), .out_slow_event(res.slow_event),
    .out_stats_kept(res.stats_kept), .out_call_count(res.call_count),
    .out_failure_count(res.failure_count), .out_latency_total_ns(res.latency_total_ns)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // word accepted at this edge: predict it
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      sb.note_word(in_command, in_thread_id, in_timestamp_ns, in_group_id,
                   in_call_number, in_call_failed);
      accepted++;
    end
  end

  // result words and the cycle limit
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_word(res);
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // present one word from a falling edge until it is taken
  task send_word(logic cmd, logic [63:0] tid, logic [63:0] ts, logic [63:0] grp,
                 logic [31:0] cnum, logic failed);
    int gap;
    int target;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command = cmd;
    in_thread_id = tid;
    in_timestamp_ns = ts;
    in_group_id = grp;
    in_call_number = cnum;
    in_call_failed = failed;
    start = 1'b1;
    target = accepted + 1;
    do @(negedge clk); while (accepted < target);
  endtask

  task drain();
    start = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task write_threshold(logic [63:0] v);
    drain();
    cfg_wdata = v;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.threshold = v;
  endtask

  // mostly pooled threads and keys with slowly advancing time, some noise
  task random_word();
    logic [63:0] tid;
    logic [63:0] ts;
    logic [63:0] grp;
    logic [31:0] cnum;
    tid = ($urandom_range(0, 19) == 0) ? rand64() : tid_pool[$urandom_range(0, 23)];
    grp = ($urandom_range(0, 19) == 0) ? rand64() : grp_pool[$urandom_range(0, 5)];
    cnum = ($urandom_range(0, 19) == 0) ? $urandom : call_pool[$urandom_range(0, 3)];
    if ($urandom_range(0, 9) < 7) begin
      now_ts += 64'($urandom_range(0, 2000));
      ts = now_ts;
    end else begin
      ts = rand64();
    end
    send_word(1'($urandom_range(0, 1)), tid, ts, grp, cnum, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [63:0] thresholds[6];
    int i;
    int k;
    sb = new();
    idle_on = 1'b0;
    now_ts = 64'd1000;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = slm_pkg::CMD_ENTER;
    in_thread_id = '0;
    in_timestamp_ns = '0;
    in_group_id = '0;
    in_call_number = '0;
    in_call_failed = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    foreach (tid_pool[j]) tid_pool[j] = rand64();
    tid_pool[0] = '0;
    tid_pool[1] = '1;
    foreach (grp_pool[j]) grp_pool[j] = rand64();
    grp_pool[0] = '0;
    grp_pool[1] = '1;
    foreach (call_pool[j]) call_pool[j] = $urandom;
    call_pool[0] = '0;
    call_pool[1] = '1;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, wrap, overwrite, unmatched exit, accumulation
    send_word(slm_pkg::CMD_ENTER, 64'd0, 64'd0, '1, '1, 1'b1);
    send_word(slm_pkg::CMD_EXIT, 64'd0, '1, '1, '1, 1'b1);
    send_word(slm_pkg::CMD_EXIT, 64'd0, 64'd5, '0, '0, 1'b0);
    send_word(slm_pkg::CMD_ENTER, '1, 64'd100, '0, '0, 1'b0);
    send_word(slm_pkg::CMD_ENTER, '1, 64'd200, '0, '0, 1'b0);
    send_word(slm_pkg::CMD_EXIT, '1, 64'd50, '0, '0, 1'b0);
    send_word(slm_pkg::CMD_ENTER, 64'h0000_0001_0000_0002, 64'd10, '0, '0, 1'b0);
    send_word(slm_pkg::CMD_EXIT, 64'h0000_0001_0000_0002,
              64'd10 + slm_pkg::THRESHOLD_RESET, '0, '0, 1'b1);
    send_word(slm_pkg::CMD_ENTER, 64'h0000_0001_0000_0002, 64'd10, '0, '0, 1'b0);
    send_word(slm_pkg::CMD_EXIT, 64'h0000_0001_0000_0002,
              64'd11 + slm_pkg::THRESHOLD_RESET, '0, '0, 1'b0);
    send_word(slm_pkg::CMD_ENTER, 64'hAAAA_AAAA_5555_5555, '1, 64'd7, 32'd9, 1'b1);
    send_word(slm_pkg::CMD_ENTER, 64'h5555_5555_AAAA_AAAA, 64'd3, 64'd7, 32'd9, 1'b1);
    send_word(slm_pkg::CMD_EXIT, 64'h5555_5555_AAAA_AAAA, 64'd2, 64'h5555_5555_AAAA_AAAA,
              32'h5555_AAAA, 1'b1);
    send_word(slm_pkg::CMD_EXIT, 64'hAAAA_AAAA_5555_5555, 64'd0, 64'hAAAA_AAAA_5555_5555,
              32'hAAAA_5555, 1'b0);
    send_word(slm_pkg::CMD_EXIT, 64'hAAAA_AAAA_5555_5555, 64'd0, '0, '0, 1'b0);

    // random phases over several thresholds, extremes among them
    thresholds[0] = slm_pkg::THRESHOLD_RESET;
    thresholds[1] = '0;
    thresholds[2] = 64'd1000;
    thresholds[3] = '1;
    thresholds[4] = rand64();
    thresholds[5] = 64'd800;
    for (k = 0; k < 6; k++) begin
      if (k > 0) write_threshold(thresholds[k]);
      for (i = 0; i < 90; i++) begin
        if (i % 30 == 0) idle_on = $urandom_range(0, 3) != 0;
        if (k == 2 && i == 46) drain();
        random_word();
      end
    end
    start = 1'b0;

    drain();
    repeat (50) @(negedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
